[sv/crsh_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the closest ray-sphere hit unit
// used by crsh_isqrt and closest_ray_sphere_hit_unit; no dependencies
package crsh_pkg;

	localparam int COORD_W     = 24;  // Q12.12 coordinate
	localparam int DIR_W       = 16;  // Q2.14 direction
	localparam int DIR_FRAC    = 14;
	localparam int RAD_W       = 23;  // unsigned Q11.12 radius
	localparam int L_W         = COORD_W + 1;
	localparam int DOT_W       = 43;  // exact sum of three L*dir products
	localparam int TH_W        = DOT_W - DIR_FRAC;
	localparam int MUL_W       = TH_W;  // shared multiplier operand width
	localparam int PROD_W      = 2 * MUL_W;
	localparam int R2_W        = 2 * RAD_W;
	localparam int RADICAND_W  = 56;
	localparam int ROOT_W      = RADICAND_W / 2;
	localparam int ROOT_CNT_W  = $clog2(ROOT_W);
	localparam int T_W         = TH_W + 1;
	localparam int DIST_W      = 24;
	localparam int MAX_SPHERES = 16;
	localparam int IDX_W       = $clog2(MAX_SPHERES);
	localparam int IN_DATA_W   = 216;
	localparam int OUT_DATA_W  = 32;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MAX_SPHERES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_CHECK,
		ST_SQRT,
		ST_ROOT,
		ST_FINISH
	} state_t;

	// products issued to the shared multiplier, in order
	typedef enum logic [2:0] {
		OP_DX,
		OP_DY,
		OP_DZ,
		OP_LX,
		OP_LY,
		OP_LZ,
		OP_RR,
		OP_TT
	} mul_op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage

[sv/closest_ray_sphere_hit_unit.sv]
`timescale 1ns / 1ps
// closest ray-sphere hit unit: one shared multiplier under a sequencer
// depends on crsh_pkg and crsh_isqrt
//
// Usage: each input transfer on the s_ group carries one ray and one sphere;
// a run of transfers tests one ray against a scene, s_tlast marks its last
// sphere. At the end of a run one result transfer leaves on the m_ group:
// m_tuser is the hit flag, m_tdata the index of the nearest sphere in the run
// and its distance (Q12.12, all ones when nothing was hit).
// Timing: s_tready is high only while the unit is idle, so an item is not taken
// before the unit is through with the last one. The work on an item runs in order:
// the eight products issue one by one through the shared 29x29
// multiplier, the last product drains, a clear miss is checked for, the
// bit-serial square root forms its 28 root bits and hands them over, the
// root is formed and the kept best is updated. When the ray clearly misses
// the sphere the root is skipped. The result of the last sphere is
// registered in the output register at the end of its final step.
// Stalls: the result sits in an output register. If it has not been taken
// when the next run ends, the unit waits in its final step until m_tready.
// Reset clears the kept best, the sphere position and the output valid.
module closest_ray_sphere_hit_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// ray_origin_x/y/z, ray_dir_x/y/z, sphere_center_x/y/z, sphere_radius, pad
	input  logic [crsh_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// hit_index, nearest_distance, pad
	output logic [crsh_pkg::OUT_DATA_W-1:0]     m_tdata,
	// any_hit
	output logic                                m_tuser
);

	crsh_pkg::state_t state_q, state_d;

	// item registers
	logic signed [crsh_pkg::L_W-1:0]   lx_q, ly_q, lz_q;
	logic signed [crsh_pkg::DIR_W-1:0] dx_q, dy_q, dz_q;
	logic [crsh_pkg::RAD_W-1:0]        r_q;
	logic                              last_q;

	// multiplier and accumulators
	crsh_pkg::mul_op_t                   op_q;
	crsh_pkg::mul_op_t                   prod_op_q;
	logic                                prod_vld_q;
	logic signed [crsh_pkg::PROD_W-1:0]  prod_q;
	logic signed [crsh_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic signed [crsh_pkg::DOT_W-1:0]   dot_q;
	logic signed [crsh_pkg::PROD_W-1:0]  sum_q;
	logic [crsh_pkg::R2_W-1:0]           r2_q;
	logic signed [crsh_pkg::TH_W-1:0]    th;

	// root and candidate
	logic                                miss;
	logic signed [crsh_pkg::PROD_W-1:0]  rad_full;
	logic                                sq_start;
	crsh_pkg::sqrt_stat_t                sq_stat;
	logic [crsh_pkg::ROOT_W-1:0]         thc;
	logic signed [crsh_pkg::T_W-1:0]     t_near, t_far, t_sel;
	logic                                root_hit;
	logic                                hit_q;
	logic [crsh_pkg::DIST_W-1:0]         dist_q;

	// kept best
	logic [crsh_pkg::DIST_W-1:0] best_dist_q;
	logic [crsh_pkg::IDX_W-1:0]  best_idx_q;
	logic                        found_q;
	logic [crsh_pkg::IDX_W-1:0]  pos_q;
	logic                        better;
	logic                        commit;
	logic                        accept;

	// output register
	logic                        m_tvalid_q;
	logic                        m_hit_q;
	logic [crsh_pkg::IDX_W-1:0]  m_idx_q;
	logic [crsh_pkg::DIST_W-1:0] m_dist_q;

	assign accept = s_tvalid && s_tready;

	// ---------------------------------------------------------------- control
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crsh_pkg::ST_IDLE:   if (accept) state_d = crsh_pkg::ST_MUL;
			crsh_pkg::ST_MUL:    if (op_q == crsh_pkg::OP_TT) state_d = crsh_pkg::ST_DRAIN;
			crsh_pkg::ST_DRAIN:  state_d = crsh_pkg::ST_CHECK;
			crsh_pkg::ST_CHECK:  state_d = miss ? crsh_pkg::ST_FINISH : crsh_pkg::ST_SQRT;
			crsh_pkg::ST_SQRT:   if (sq_stat.done) state_d = crsh_pkg::ST_ROOT;
			crsh_pkg::ST_ROOT:   state_d = crsh_pkg::ST_FINISH;
			crsh_pkg::ST_FINISH: if (commit) state_d = crsh_pkg::ST_IDLE;
			default:             state_d = crsh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == crsh_pkg::ST_IDLE);
		sq_start = (state_q == crsh_pkg::ST_CHECK) && !miss;
		commit   = (state_q == crsh_pkg::ST_FINISH) &&
		           (!last_q || !m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= crsh_pkg::ST_IDLE;
			prod_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			best_dist_q <= crsh_pkg::DIST_MAX;
			best_idx_q <= '0;
			found_q    <= 1'b0;
			pos_q      <= '0;
		end else begin
			state_q    <= state_d;
			prod_vld_q <= (state_q == crsh_pkg::ST_MUL);
			if (commit && last_q) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (commit) begin
				if (last_q) begin
					best_dist_q <= crsh_pkg::DIST_MAX;
					best_idx_q  <= '0;
					found_q     <= 1'b0;
					pos_q       <= '0;
				end else begin
					if (better) begin
						best_dist_q <= dist_q;
						best_idx_q  <= pos_q;
						found_q     <= 1'b1;
					end
					if (pos_q != crsh_pkg::IDX_LAST) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

	assign better = hit_q && (!found_q || dist_q < best_dist_q);

	// ---------------------------------------------------------------- datapath
	assign th = dot_q[crsh_pkg::DOT_W-1:crsh_pkg::DIR_FRAC];  // floor shift

	always_comb begin
		unique case (op_q)
			crsh_pkg::OP_DX: begin
				mul_a = crsh_pkg::MUL_W'(lx_q);
				mul_b = crsh_pkg::MUL_W'(dx_q);
			end
			crsh_pkg::OP_DY: begin
				mul_a = crsh_pkg::MUL_W'(ly_q);
				mul_b = crsh_pkg::MUL_W'(dy_q);
			end
			crsh_pkg::OP_DZ: begin
				mul_a = crsh_pkg::MUL_W'(lz_q);
				mul_b = crsh_pkg::MUL_W'(dz_q);
			end
			crsh_pkg::OP_LX: begin
				mul_a = crsh_pkg::MUL_W'(lx_q);
				mul_b = crsh_pkg::MUL_W'(lx_q);
			end
			crsh_pkg::OP_LY: begin
				mul_a = crsh_pkg::MUL_W'(ly_q);
				mul_b = crsh_pkg::MUL_W'(ly_q);
			end
			crsh_pkg::OP_LZ: begin
				mul_a = crsh_pkg::MUL_W'(lz_q);
				mul_b = crsh_pkg::MUL_W'(lz_q);
			end
			crsh_pkg::OP_RR: begin
				mul_a = $signed({{(crsh_pkg::MUL_W - crsh_pkg::RAD_W){1'b0}}, r_q});
				mul_b = $signed({{(crsh_pkg::MUL_W - crsh_pkg::RAD_W){1'b0}}, r_q});
			end
			crsh_pkg::OP_TT: begin
				mul_a = th;
				mul_b = th;
			end
		endcase
	end

	assign miss     = sum_q > $signed({{(crsh_pkg::PROD_W - crsh_pkg::R2_W){1'b0}}, r2_q});
	assign rad_full = $signed({{(crsh_pkg::PROD_W - crsh_pkg::R2_W){1'b0}}, r2_q}) - sum_q;

	crsh_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (rad_full[crsh_pkg::RADICAND_W-1:0]),
		.stat     (sq_stat),
		.root     (thc)
	);

	// near root first, far root when the near one lies behind the origin
	assign t_near   = crsh_pkg::T_W'(th) - $signed({1'b0, 1'b0, thc});
	assign t_far    = crsh_pkg::T_W'(th) + $signed({1'b0, 1'b0, thc});
	assign t_sel    = t_near[crsh_pkg::T_W-1] ? t_far : t_near;
	assign root_hit = !t_sel[crsh_pkg::T_W-1];

	always_ff @(posedge clk) begin
		if (accept) begin
			lx_q <= crsh_pkg::L_W'($signed(s_tdata[143:120])) - crsh_pkg::L_W'($signed(s_tdata[23:0]));
			ly_q <= crsh_pkg::L_W'($signed(s_tdata[167:144])) - crsh_pkg::L_W'($signed(s_tdata[47:24]));
			lz_q <= crsh_pkg::L_W'($signed(s_tdata[191:168])) - crsh_pkg::L_W'($signed(s_tdata[71:48]));
			dx_q   <= s_tdata[87:72];
			dy_q   <= s_tdata[103:88];
			dz_q   <= s_tdata[119:104];
			r_q    <= s_tdata[214:192];
			last_q <= s_tlast;
			op_q   <= crsh_pkg::OP_DX;
			dot_q  <= '0;
			sum_q  <= '0;
		end else begin
			if (state_q == crsh_pkg::ST_MUL && op_q != crsh_pkg::OP_TT) begin
				op_q <= crsh_pkg::mul_op_t'(op_q + 1'b1);
			end
			if (prod_vld_q) begin
				case (prod_op_q) inside
					crsh_pkg::OP_DX, crsh_pkg::OP_DY, crsh_pkg::OP_DZ:
						dot_q <= dot_q + prod_q[crsh_pkg::DOT_W-1:0];
					crsh_pkg::OP_LX, crsh_pkg::OP_LY, crsh_pkg::OP_LZ:
						sum_q <= sum_q + prod_q;
					crsh_pkg::OP_RR:
						r2_q <= prod_q[crsh_pkg::R2_W-1:0];
					default:
						sum_q <= sum_q - prod_q;  // d2 = |L|^2 - th^2
				endcase
			end
		end
		prod_q    <= mul_a * mul_b;
		prod_op_q <= op_q;
		if (state_q == crsh_pkg::ST_CHECK) begin
			hit_q <= 1'b0;
		end else if (state_q == crsh_pkg::ST_ROOT) begin
			hit_q  <= root_hit;
			dist_q <= (t_sel[crsh_pkg::T_W-1:crsh_pkg::DIST_W] != '0) ? crsh_pkg::DIST_MAX
			                                                          : t_sel[crsh_pkg::DIST_W-1:0];
		end
		if (commit && last_q) begin
			m_hit_q  <= found_q || better;
			m_idx_q  <= better ? pos_q : best_idx_q;
			m_dist_q <= better ? dist_q : best_dist_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_hit_q;
	assign m_tdata  = {{(crsh_pkg::OUT_DATA_W - crsh_pkg::DIST_W - crsh_pkg::IDX_W){1'b0}},
	                   m_dist_q, m_idx_q};

	// ---------------------------------------------------------------- checks
	a_empty_best: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> (best_dist_q == crsh_pkg::DIST_MAX && best_idx_q == '0))
		else $error("empty best holds a distance or index");

	a_sqrt_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crsh_pkg::ST_SQRT) |-> (sq_stat.busy || sq_stat.done))
		else $error("waiting on an idle square root unit");

	a_ready_idle_root: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sq_stat.busy)
		else $error("ready while the square root is running");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == crsh_pkg::ST_MUL && op_q == crsh_pkg::OP_DX))
		else $error("transfer did not start the product sequence");

	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && last_q) |-> (!m_tvalid_q || m_tready))
		else $error("result written over one not yet taken");

endmodule

[sv/crsh_isqrt.sv]
`timescale 1ns / 1ps
// floor integer square root, restoring method, one result bit per cycle
// depends on crsh_pkg for widths and the status struct
module crsh_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [crsh_pkg::RADICAND_W-1:0]   radicand,
	output crsh_pkg::sqrt_stat_t              stat,
	output logic [crsh_pkg::ROOT_W-1:0]       root
);

	localparam int REM_W = crsh_pkg::ROOT_W + 2;

	logic                              busy_q;
	logic                              done_q;
	logic [crsh_pkg::ROOT_CNT_W-1:0]   cnt_q;
	logic [crsh_pkg::RADICAND_W-1:0]   rad_q;
	logic [REM_W-1:0]                  rem_q;
	logic [crsh_pkg::ROOT_W-1:0]       root_q;

	logic [REM_W+1:0] rem_shift;
	logic [REM_W+1:0] trial;
	logic             fits;
	logic             last_step;

	assign rem_shift = {rem_q, rad_q[crsh_pkg::RADICAND_W-1 -: 2]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign fits      = (rem_shift >= trial);
	assign last_step = (cnt_q == crsh_pkg::ROOT_CNT_W'(crsh_pkg::ROOT_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[crsh_pkg::RADICAND_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(rem_shift - trial);
				root_q <= {root_q[crsh_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift[REM_W-1:0];
				root_q <= {root_q[crsh_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

[tb/closest_ray_sphere_hit_unit_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of closest_ray_sphere_hit_unit: directed and random ray/sphere runs
// depends on crsh_pkg and the unit's rtl; results are predicted in the bench
module closest_ray_sphere_hit_unit_tb;

	localparam int ONE            = 4096;   // 1.0 in Q12.12
	localparam int UNIT_DIR       = 16384;  // 1.0 in Q2.14
	localparam int HOLD_CYCLES    = 500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;

	typedef struct packed {
		logic signed [23:0] ox, oy, oz;
		logic signed [15:0] dx, dy, dz;
	} ray_t;

	typedef struct packed {
		logic signed [23:0] ox, oy, oz;
		logic signed [15:0] dx, dy, dz;
		logic signed [23:0] cx, cy, cz;
		logic [22:0]        rad;
		logic               last_sphere;
	} sphere_item_t;

	typedef struct packed {
		logic        any_hit;
		logic [3:0]  idx;
		logic [23:0] distance;
	} hit_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [crsh_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            s_tlast;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [crsh_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tuser;

	// kept best of the run in progress
	logic [23:0] best_dist_q  = crsh_pkg::DIST_MAX;
	logic [3:0]  best_idx_q   = '0;
	logic        found_q      = 1'b0;
	logic [3:0]  position_q   = '0;

	hit_result_t expected_hits[$];
	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	int          burst_left     = 0;
	bit          steady         = 1'b0;
	bit          hold_req       = 1'b0;

	closest_ray_sphere_hit_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor integer square root, two bits per step
	function automatic longint floor_root(input longint v);
		longint rem, res, b;
		rem = v;
		res = 0;
		b = longint'(1) <<< 62;
		while (b > rem)
			b = b >>> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	function automatic bit sphere_hit_distance(input sphere_item_t it,
			output logic [23:0] distance);
		longint lx, ly, lz, th, r2, d2, thc, t;
		lx = longint'($signed(it.cx)) - longint'($signed(it.ox));
		ly = longint'($signed(it.cy)) - longint'($signed(it.oy));
		lz = longint'($signed(it.cz)) - longint'($signed(it.oz));
		th = (lx * longint'($signed(it.dx)) + ly * longint'($signed(it.dy))
			+ lz * longint'($signed(it.dz))) >>> crsh_pkg::DIR_FRAC;
		r2 = longint'(it.rad) * longint'(it.rad);
		d2 = lx * lx + ly * ly + lz * lz - th * th;
		distance = crsh_pkg::DIST_MAX;
		if (d2 > r2)
			return 1'b0;
		thc = floor_root(r2 - d2);
		t = th - thc;
		if (t < 0) begin
			// near root behind the origin: take the far root
			t = th + thc;
			if (t < 0)
				return 1'b0;
		end
		distance = (t > longint'(crsh_pkg::DIST_MAX)) ? crsh_pkg::DIST_MAX : t[23:0];
		return 1'b1;
	endfunction

	function automatic void track_item(input sphere_item_t it);
		logic [23:0] d;
		bit          h;
		h = sphere_hit_distance(it, d);
		// strictly closer only, so the earlier sphere keeps a tie
		if (h && (!found_q || d < best_dist_q)) begin
			best_dist_q = d;
			best_idx_q  = position_q;
			found_q     = 1'b1;
		end
		if (position_q != crsh_pkg::IDX_LAST)
			position_q = position_q + 4'd1;
		if (it.last_sphere) begin
			expected_hits.push_back('{any_hit: found_q, idx: best_idx_q,
				distance: best_dist_q});
			best_dist_q = crsh_pkg::DIST_MAX;
			best_idx_q  = '0;
			found_q     = 1'b0;
			position_q  = '0;
		end
	endfunction

	function automatic sphere_item_t make_item(input int ox, oy, oz, dx, dy, dz,
			input int cx, cy, cz, rad, input bit last_sphere);
		sphere_item_t it;
		it.ox = 24'(ox);
		it.oy = 24'(oy);
		it.oz = 24'(oz);
		it.dx = 16'(dx);
		it.dy = 16'(dy);
		it.dz = 16'(dz);
		it.cx = 24'(cx);
		it.cy = 24'(cy);
		it.cz = 24'(cz);
		it.rad = 23'(rad);
		it.last_sphere = last_sphere;
		return it;
	endfunction

	function automatic logic [23:0] to_coord(input real v);
		if (v > 8388607.0)
			return 24'h7FFFFF;
		if (v < -8388608.0)
			return 24'h800000;
		return 24'($rtoi(v));
	endfunction

	function automatic ray_t random_ray();
		ray_t ray;
		real  ax, ay, az, norm;
		ray.ox = 24'(int'($urandom_range(0, 8388606)) - 4194303);
		ray.oy = 24'(int'($urandom_range(0, 8388606)) - 4194303);
		ray.oz = 24'(int'($urandom_range(0, 8388606)) - 4194303);
		ax = real'($urandom_range(0, 2000)) - 1000.0;
		ay = real'($urandom_range(0, 2000)) - 1000.0;
		az = real'($urandom_range(0, 2000)) - 1000.0;
		norm = $sqrt(ax * ax + ay * ay + az * az);
		if (norm < 1.0) begin
			ax = 1000.0;
			norm = 1000.0;
		end
		ray.dx = 16'($rtoi(ax / norm * 16383.0));
		ray.dy = 16'($rtoi(ay / norm * 16383.0));
		ray.dz = 16'($rtoi(az / norm * 16383.0));
		return ray;
	endfunction

	// sphere placed near the ray at a random distance, sometimes behind the origin
	function automatic sphere_item_t aimed_sphere(input ray_t ray);
		sphere_item_t it;
		real          t, rad, spread;
		t = (real'($urandom_range(0, 4000)) - 500.0) * 409.6;
		rad = real'($urandom_range(0, 40 * ONE));
		if ($urandom_range(0, 19) == 0)
			rad = real'($urandom_range(0, 8388607));
		spread = rad * 1.5 + 4096.0;
		it.ox = ray.ox;
		it.oy = ray.oy;
		it.oz = ray.oz;
		it.dx = ray.dx;
		it.dy = ray.dy;
		it.dz = ray.dz;
		it.cx = to_coord(real'($signed(ray.ox)) + real'($signed(ray.dx)) / 16384.0 * t
			+ (real'($urandom_range(0, 2000)) / 1000.0 - 1.0) * spread);
		it.cy = to_coord(real'($signed(ray.oy)) + real'($signed(ray.dy)) / 16384.0 * t
			+ (real'($urandom_range(0, 2000)) / 1000.0 - 1.0) * spread);
		it.cz = to_coord(real'($signed(ray.oz)) + real'($signed(ray.dz)) / 16384.0 * t
			+ (real'($urandom_range(0, 2000)) / 1000.0 - 1.0) * spread);
		it.rad = 23'($rtoi(rad));
		it.last_sphere = 1'b0;
		return it;
	endfunction

	function automatic sphere_item_t noise_item();
		sphere_item_t it;
		it.ox = 24'($urandom);
		it.oy = 24'($urandom);
		it.oz = 24'($urandom);
		it.dx = 16'($urandom);
		it.dy = 16'($urandom);
		it.dz = 16'($urandom);
		it.cx = 24'($urandom);
		it.cy = 24'($urandom);
		it.cz = 24'($urandom);
		it.rad = 23'($urandom);
		it.last_sphere = 1'b0;
		return it;
	endfunction

	// offers one item until the transfer, then maybe pauses before the next
	task automatic send_item(input sphere_item_t it);
		s_tdata  <= {1'b0, it.rad, it.cz, it.cy, it.cx, it.dz, it.dy, it.dx, it.oz, it.oy, it.ox};
		s_tlast  <= it.last_sphere;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		track_item(it);
		if (!steady) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 50)) @(posedge clk);
				burst_left = $urandom_range(0, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want, got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	task automatic test_field_extremes();
		send_item(make_item(8388607, 8388607, 8388607, 32767, -32768, 32767,
			-8388608, -8388608, -8388608, 8388607, 1'b1));
		send_item(make_item(-8388608, -8388608, -8388608, -32768, 32767, -32768,
			8388607, 8388607, 8388607, 0, 1'b1));
		// degenerate: zero direction, zero radius, centre on the origin
		send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
		send_item(make_item(-1, -1, -1, -1, -1, -1, 8388607, -8388608, 1, 8388607, 1'b1));
	endtask

	task automatic test_sphere_cases();
		// hit in front on the near root
		send_item(make_item(0, 0, 0, UNIT_DIR, 0, 0, 10 * ONE, 0, 0, 2 * ONE, 1'b1));
		// origin inside the sphere, far root
		send_item(make_item(0, 0, 0, UNIT_DIR, 0, 0, ONE, 0, 0, 3 * ONE, 1'b1));
		// sphere behind the origin
		send_item(make_item(0, 0, 0, UNIT_DIR, 0, 0, -10 * ONE, 0, 0, 2 * ONE, 1'b1));
		// passes beside the sphere
		send_item(make_item(0, 0, 0, UNIT_DIR, 0, 0, 10 * ONE, 5 * ONE, 0, 2 * ONE, 1'b1));
		// grazing hit
		send_item(make_item(0, 0, 0, UNIT_DIR, 0, 0, 10 * ONE, 2 * ONE, 0, 2 * ONE, 1'b1));
		// long non-unit ray across the field: a hit whose distance stays within the 24-bit range
		send_item(make_item(-8388608, 0, 0, 32767, 0, 0, 8388607, 0, 0, ONE, 1'b1));
		// non-unit direction drives d2 negative
		send_item(make_item(0, 0, 0, 32767, 32767, 32767, ONE, ONE, ONE, 0, 1'b1));
	endtask

	task automatic test_run_order();
		send_item(make_item(0, 0, 0, 0, UNIT_DIR, 0, 0, -9 * ONE, 0, ONE, 1'b0));
		send_item(make_item(0, 0, 0, 0, UNIT_DIR, 0, 0, 10 * ONE, 0, 2 * ONE, 1'b0));
		send_item(make_item(0, 0, 0, 0, UNIT_DIR, 0, 0, 10 * ONE, 0, 2 * ONE, 1'b1));
		// a closer later sphere replaces the kept one
		send_item(make_item(0, 0, 0, 0, 0, UNIT_DIR, 0, 0, 22 * ONE, 2 * ONE, 1'b0));
		send_item(make_item(0, 0, 0, 0, 0, UNIT_DIR, 0, 0, 10 * ONE, 2 * ONE, 1'b0));
		send_item(make_item(0, 0, -8388608, 0, 0, 32767, 0, 0, 8388607, ONE, 1'b1));
		// a hit after a miss in the same run still reports a hit
		send_item(make_item(0, 0, 0, UNIT_DIR, 0, 0, -10 * ONE, 0, 0, ONE, 1'b0));
		send_item(make_item(-8388608, 0, 0, 32767, 0, 0, 8388607, 0, 0, ONE, 1'b1));
	endtask

	task automatic test_random_runs(input int n_items);
		int           sent, len, kind;
		ray_t         ray;
		sphere_item_t it, prev;
		sent = 0;
		prev = noise_item();
		while (sent < n_items) begin
			if ($urandom_range(0, 29) == 0)
				steady = !steady;
			kind = $urandom_range(0, 9);
			if (kind < 7)
				len = $urandom_range(1, 6);
			else if (kind < 9)
				len = $urandom_range(7, 14);
			else
				len = $urandom_range(15, 20);
			ray = random_ray();
			for (int k = 0; k < len; k++) begin
				kind = $urandom_range(0, 9);
				if (kind < 7)
					it = aimed_sphere(ray);
				else if (kind == 7 && k > 0)
					it = prev;  // repeated sphere makes a tie
				else
					it = noise_item();
				it.last_sphere = (k == len - 1);
				send_item(it);
				prev = it;
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	// receiver holds off while several one-sphere runs pile up behind the output register
	task automatic test_output_hold();
		sphere_item_t it;
		steady = 1'b1;
		hold_req = 1'b1;
		repeat (5) begin
			it = aimed_sphere(random_ray());
			it.last_sphere = 1'b1;
			send_item(it);
		end
		steady = 1'b0;
	endtask

	initial begin : receiver
		int span;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				span = $urandom_range(1, 12);
				m_tready <= ($urandom_range(0, 2) != 0);
				repeat (span) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		hit_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_hits.size() == 0) begin
				note_mismatch("unexpected result", '0, m_tdata);
			end else begin
				want = expected_hits.pop_front();
				if (m_tuser !== want.any_hit)
					note_mismatch("any_hit", 32'(want.any_hit), 32'(m_tuser));
				if (m_tdata[3:0] !== want.idx)
					note_mismatch("hit_index", 32'(want.idx), 32'(m_tdata[3:0]));
				if (m_tdata[27:4] !== want.distance)
					note_mismatch("nearest_distance", 32'(want.distance), 32'(m_tdata[27:4]));
			end
		end
	end

	// ends the run when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("closest_ray_sphere_hit_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_sphere_cases();
		test_run_order();
		test_random_runs(700);
		test_output_hold();
		test_random_runs(630);

		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("closest_ray_sphere_hit_unit_tb: done, clean");
		else
			$display("closest_ray_sphere_hit_unit_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
sv/crsh_pkg.sv
sv/crsh_isqrt.sv
sv/closest_ray_sphere_hit_unit.sv
tb/closest_ray_sphere_hit_unit_tb.sv
